[rtl/hlfd_pkg.sv]
// ----------------------------------------------------------------------------
// hlfd_pkg
// Shared types and constants for the header/length frame deframer.
// ----------------------------------------------------------------------------
package hlfd_pkg;

    // Register word indexes on the configuration port
    localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [1:0] REG_HDR_THIRD  = 2'd2;

    // Header defaults: 'L', 'i', 'f'
    localparam logic [7:0] HDR_FIRST_RST  = 8'd76;
    localparam logic [7:0] HDR_SECOND_RST = 8'd105;
    localparam logic [7:0] HDR_THIRD_RST  = 8'd102;

    localparam int unsigned LEN_W = 16;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_HDR1 = 6'b000001,
        PH_HDR2 = 6'b000010,
        PH_HDR3 = 6'b000100,
        PH_LENH = 6'b001000,
        PH_LENL = 6'b010000,
        PH_DATA = 6'b100000
    } hlfd_phase_t;

    // Expected header bytes
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } hlfd_hdr_t;

    // Result of one parsed byte
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } hlfd_res_t;

    // Parser status, for checks at the top level
    typedef struct packed {
        hlfd_phase_t      phase;
        logic [LEN_W-1:0] remaining;
    } hlfd_stat_t;

endpackage

[rtl/header_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// header_length_frame_deframer
// Hunts a three-byte header, reads a 16-bit big-endian length and passes
// the payload bytes out one word at a time, flagging the frame's last byte.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  input     in         in_valid / in_stall      rx_byte
//  output    out        out_valid / out_stall    payload_byte, last_in_frame
//  config    in         APB psel/penable/pready  paddr, pwdata, prdata
//
//  One word per cycle sustained while out_stall stays low; an input word
//  passes the input register, then the parser and the result register.
//  Header and length words, and a zero length, produce no result word.
//  in_stall rises only when the result register is held by out_stall and
//  the waiting input word would produce a result.
//  rst_n clears the phase and the payload count and restores the default
//  header bytes.
// ----------------------------------------------------------------------------
module header_length_frame_deframer
    import hlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        last_in_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hlfd_hdr_t  hdr;
    hlfd_res_t  res;
    hlfd_stat_t stat;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       advance;

    hlfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hdr     (hdr)
    );

    // Input register stage
    assign advance  = in_valid_reg && (out_free || !res.valid);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    hlfd_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .hdr     (hdr),
        .res     (res),
        .stat    (stat)
    );

    hlfd_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res.valid),
        .res           (res),
        .out_stall     (out_stall),
        .free          (out_free),
        .out_valid     (out_valid),
        .payload_byte  (payload_byte),
        .last_in_frame (last_in_frame)
    );

    // Checks
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_data_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.phase == PH_DATA) |-> (stat.remaining != '0))
        else $error("payload phase with zero count");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid && res.last) |=> (stat.phase == PH_HDR1))
        else $error("frame did not end after last byte");

    a_result_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid) |=> (out_valid && payload_byte == $past(in_byte_reg)))
        else $error("result word not registered");

endmodule

[rtl/hlfd_regs.sv]
// ----------------------------------------------------------------------------
// hlfd_regs
// APB-style register file holding the three expected header bytes.
// ----------------------------------------------------------------------------
module hlfd_regs
    import hlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output hlfd_hdr_t   hdr
);

    hlfd_hdr_t  hdr_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg.first  <= HDR_FIRST_RST;
            hdr_reg.second <= HDR_SECOND_RST;
            hdr_reg.third  <= HDR_THIRD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HDR_FIRST:  hdr_reg.first  <= pwdata[7:0];
                REG_HDR_SECOND: hdr_reg.second <= pwdata[7:0];
                REG_HDR_THIRD:  hdr_reg.third  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux; unmapped word reads as zero
    always_comb
    begin
        case (reg_idx)
            REG_HDR_FIRST:  prdata = {24'd0, hdr_reg.first};
            REG_HDR_SECOND: prdata = {24'd0, hdr_reg.second};
            REG_HDR_THIRD:  prdata = {24'd0, hdr_reg.third};
            default:        prdata = 32'd0;
        endcase
    end

    assign hdr = hdr_reg;

endmodule

[rtl/hlfd_parse.sv]
// ----------------------------------------------------------------------------
// hlfd_parse
// Header hunt, length capture and payload count. Updates on each step.
// ----------------------------------------------------------------------------
module hlfd_parse
    import hlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  hlfd_hdr_t  hdr,
    output hlfd_res_t  res,
    output hlfd_stat_t stat
);

    hlfd_phase_t      phase_reg, phase_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic [LEN_W-1:0] len_full;

    assign len_full = {remaining_reg[LEN_W-1:8], byte_in};

    // Next phase, count and result
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        res.valid      = 1'b0;
        res.data       = byte_in;
        res.last       = 1'b0;
        case (phase_reg)
            PH_HDR1: phase_next = (byte_in == hdr.first)  ? PH_HDR2 : PH_HDR1;
            PH_HDR2: phase_next = (byte_in == hdr.second) ? PH_HDR3 : PH_HDR1;
            PH_HDR3: phase_next = (byte_in == hdr.third)  ? PH_LENH : PH_HDR1;
            PH_LENH:
            begin
                remaining_next = {byte_in, 8'd0};
                phase_next     = PH_LENL;
            end
            PH_LENL:
            begin
                remaining_next = len_full;
                phase_next     = (len_full == '0) ? PH_HDR1 : PH_DATA;
            end
            PH_DATA:
            begin
                remaining_next = remaining_reg - LEN_W'(1);
                res.valid      = 1'b1;
                res.last       = (remaining_reg == LEN_W'(1));
                phase_next     = res.last ? PH_HDR1 : PH_DATA;
            end
            default: phase_next = PH_HDR1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR1;
            remaining_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

    assign stat.phase     = phase_reg;
    assign stat.remaining = remaining_reg;

endmodule

[rtl/hlfd_out.sv]
// ----------------------------------------------------------------------------
// hlfd_out
// Result register on the output channel; holds a word while stalled.
// ----------------------------------------------------------------------------
module hlfd_out
    import hlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  hlfd_res_t  res,
    input  logic       out_stall,
    output logic       free,
    output logic       out_valid,
    output logic [7:0] payload_byte,
    output logic       last_in_frame
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // Slot can take a word if empty or being drained this cycle
    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign out_valid     = valid_reg;
    assign payload_byte  = data_reg;
    assign last_in_frame = last_reg;

endmodule

[tb/sv/tb_header_length_frame_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_header_length_frame_deframer
// Self-checking bench for the header/length frame deframer. Received bytes
// go in as words with random gaps while the result side stalls at random.
// A local copy of the parser predicts every payload word, and each result
// word is compared in order with that prediction. Header registers are
// rewritten over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb_header_length_frame_deframer
    import hlfd_pkg::*;
();

    localparam logic [1:0]  REG_UNUSED    = 2'd3;
    localparam int unsigned MAX_GAP       = 12;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned SECTION_WORDS = 160;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = 4'h0;
    logic [31:0] pwdata    = 32'h0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  payload_byte;
    logic        last_in_frame;
    logic [31:0] prdata;
    logic        pready;

    header_length_frame_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .last_in_frame (last_in_frame),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // Parser copy and expected payload words
    hlfd_hdr_t   hdr_model;
    hlfd_phase_t phase_model;
    logic [15:0] left_model;
    hlfd_res_t   payload_expect_q[$];

    int unsigned err_count    = 0;
    int unsigned words_sent   = 0;
    int unsigned hold_cycles  = 0;
    bit          send_idle_en = 1'b1;
    bit          recv_idle_en = 1'b1;

    // Advance the parser copy by one received byte
    function automatic void deframe_byte(input logic [7:0] b);
        hlfd_res_t r;
        case (phase_model)
            PH_HDR1:
            begin
                if (b == hdr_model.first) phase_model = PH_HDR2;
                else                      phase_model = PH_HDR1;
            end
            PH_HDR2:
            begin
                if (b == hdr_model.second) phase_model = PH_HDR3;
                else                       phase_model = PH_HDR1;
            end
            PH_HDR3:
            begin
                if (b == hdr_model.third) phase_model = PH_LENH;
                else                      phase_model = PH_HDR1;
            end
            PH_LENH:
            begin
                left_model  = {b, 8'h00};
                phase_model = PH_LENL;
            end
            PH_LENL:
            begin
                left_model[7:0] = b;
                if (left_model == 16'd0) phase_model = PH_HDR1;
                else                     phase_model = PH_DATA;
            end
            PH_DATA:
            begin
                left_model = left_model - 16'd1;
                r.valid    = 1'b1;
                r.data     = b;
                r.last     = (left_model == 16'd0);
                if (r.last) phase_model = PH_HDR1;
                payload_expect_q.push_back(r);
            end
            default:
                phase_model = PH_HDR1;
        endcase
    endfunction

    // Offer one word after a random gap; returns at the accepting edge
    task automatic send_word(input logic [7:0] b);
        int unsigned gap;
        gap = send_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        deframe_byte(b);
        words_sent++;
    endtask

    // Let every expected word come out, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (payload_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Well-formed frame with random payload under the current header
    task automatic send_frame(input logic [15:0] len);
        send_word(hdr_model.first);
        send_word(hdr_model.second);
        send_word(hdr_model.third);
        send_word(len[15:8]);
        send_word(len[7:0]);
        for (int unsigned i = 0; i < len; i++)
            send_word(8'($urandom()));
    endtask

    // Part of a header, then a byte that breaks it
    task automatic send_broken_header();
        int unsigned good;
        logic [7:0]  want;
        logic [7:0]  bad;
        good = $urandom_range(0, 2);
        if (good > 0) send_word(hdr_model.first);
        if (good > 1) send_word(hdr_model.second);
        case (good)
            0:       want = hdr_model.first;
            1:       want = hdr_model.second;
            default: want = hdr_model.third;
        endcase
        bad = 8'($urandom());
        while (bad == want) bad = 8'($urandom());
        send_word(bad);
    endtask

    // APB write: setup, access, then idle
    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] noise;
        noise   = $urandom();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise[31:8], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HDR_FIRST:  hdr_model.first  = val;
            REG_HDR_SECOND: hdr_model.second = val;
            REG_HDR_THIRD:  hdr_model.third  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // APB read and compare with the local register copy
    task automatic apb_check(input logic [1:0] idx);
        logic [7:0] want;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_HDR_FIRST:  want = hdr_model.first;
            REG_HDR_SECOND: want = hdr_model.second;
            default:        want = hdr_model.third;
        endcase
        if (prdata !== {24'h0, want})
        begin
            $error("prdata[%0d]: expected %0h, actual %0h", idx, {24'h0, want}, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_header(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] h3);
        apb_write(REG_HDR_FIRST, h1);
        apb_write(REG_HDR_SECOND, h2);
        apb_write(REG_HDR_THIRD, h3);
        apb_check(REG_HDR_FIRST);
        apb_check(REG_HDR_SECOND);
        apb_check(REG_HDR_THIRD);
    endtask

    // Default header: short frames, zero length, broken headers
    task automatic test_directed_frames();
        logic [7:0] byte_list [23];
        byte_list = '{HDR_FIRST_RST, HDR_SECOND_RST, HDR_THIRD_RST, 8'h00, 8'h01, 8'h00,
                      HDR_FIRST_RST, HDR_SECOND_RST, HDR_THIRD_RST, 8'h00, 8'h00,
                      HDR_FIRST_RST, HDR_FIRST_RST,
                      HDR_FIRST_RST, HDR_SECOND_RST, 8'h78,
                      HDR_FIRST_RST, HDR_SECOND_RST, HDR_THIRD_RST, 8'h00, 8'h02,
                      8'hFF, 8'h80};
        foreach (byte_list[i])
            send_word(byte_list[i]);
        drain();
    endtask

    // Header registers at their extremes, an unused index, then defaults
    task automatic test_header_registers();
        set_header(8'h00, 8'h00, 8'h00);
        apb_write(REG_UNUSED, 8'($urandom()));
        apb_check(REG_HDR_FIRST);
        apb_check(REG_HDR_SECOND);
        apb_check(REG_HDR_THIRD);
        send_frame(16'd3);
        send_frame(16'd0);
        send_frame(16'd1);
        drain();
        set_header(8'hFF, 8'hFF, 8'hFF);
        send_frame(16'd2);
        send_broken_header();
        send_frame(16'd0);
        send_frame(16'd4);
        drain();
        set_header(8'($urandom()), 8'($urandom()), 8'($urandom()));
        send_frame(16'd3);
        drain();
        set_header(HDR_FIRST_RST, HDR_SECOND_RST, HDR_THIRD_RST);
        send_frame(16'd2);
        drain();
    endtask

    // Receiver holds off for a long stretch while a 256-byte frame streams in
    task automatic test_output_backpressure();
        send_idle_en = 1'b0;
        hold_cycles  = 150;
        send_frame(16'h0100);
        drain();
        send_idle_en = 1'b1;
    endtask

    // Mostly well-formed frames with random content, some noise and breaks
    task automatic test_random_traffic();
        int unsigned start;
        int unsigned pick;
        int unsigned mode;
        for (int section = 0; section < 4; section++)
        begin
            set_header(8'($urandom()), 8'($urandom()), 8'($urandom()));
            mode         = $urandom_range(0, 5);
            send_idle_en = (mode != 1) && (mode != 3);
            recv_idle_en = (mode != 2) && (mode != 3);
            start        = words_sent;
            while (words_sent - start < SECTION_WORDS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_frame(16'($urandom_range(17, 40)));
                    else
                        send_frame(16'($urandom_range(0, 6)));
                end
                else if (pick < 9)
                    send_broken_header();
                else
                    repeat ($urandom_range(1, 4)) send_word(8'($urandom()));
            end
            drain();
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // Result side: random stall per word, check each accepted word
    initial
    begin
        int unsigned n;
        hlfd_res_t   want;
        @(posedge rst_n);
        forever
        begin
            n = recv_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_cycles != 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
            end
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (payload_expect_q.size() == 0)
            begin
                $error("unexpected word: payload_byte %0h, last_in_frame %0b",
                       payload_byte, last_in_frame);
                err_count++;
            end
            else
            begin
                want = payload_expect_q.pop_front();
                if (payload_byte !== want.data)
                begin
                    $error("payload_byte: expected %0h, actual %0h", want.data, payload_byte);
                    err_count++;
                end
                if (last_in_frame !== want.last)
                begin
                    $error("last_in_frame: expected %0b, actual %0b", want.last,
                           last_in_frame);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("tb_header_length_frame_deframer: FAIL");
        $finish;
    end

    initial
    begin
        hdr_model   = '{first: HDR_FIRST_RST, second: HDR_SECOND_RST, third: HDR_THIRD_RST};
        phase_model = PH_HDR1;
        left_model  = 16'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_header_registers();
        test_output_backpressure();
        test_random_traffic();

        drain();
        repeat (8) @(posedge clk);
        if (err_count == 0 && payload_expect_q.size() == 0)
            $display("tb_header_length_frame_deframer: PASS");
        else
            $display("tb_header_length_frame_deframer: FAIL");
        $finish;
    end

endmodule

[header_length_frame_deframer.f]
rtl/hlfd_pkg.sv
rtl/hlfd_regs.sv
rtl/hlfd_parse.sv
rtl/hlfd_out.sv
rtl/header_length_frame_deframer.sv
tb/sv/tb_header_length_frame_deframer.sv
